[design/deq_pkg.sv]
package deq_pkg;

   localparam int CMD_W  = 3;
   localparam int WORD_W = 32;

   localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SIZE      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_EMPTY     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FRONT     = 3'd6;
   localparam logic [CMD_W-1:0] CMD_BACK      = 3'd7;

   localparam logic signed [WORD_W-1:0] EMPTY_POP_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      logic                     empty_flag;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic                     use_mem;
      logic signed [WORD_W-1:0] value;
      logic                     flag;
   } stage_type;

endpackage

[design/deq_ram.sv]
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/deq_ctrl.sv]
module deq_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  deq_pkg::req_type              req,
   output logic                          wr_en,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output logic [deq_pkg::WORD_W-1:0]    wr_data,
   output logic                          rd_en,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   output deq_pkg::stage_type            stage
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic          empty;
   logic          full;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] back_sum;
   logic [AW-1:0] tail_pos;
   logic [AW-1:0] back_pos;

   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == CW'(DEPTH));
      head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      tail_sum = SW'(head_ff) + SW'(count_ff);
      back_sum = tail_sum - SW'(1);
      tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
      back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_pos;
      wr_data       = req.push_value;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      stage.valid   = 1'b0;
      stage.use_mem = 1'b0;
      stage.value   = '0;
      stage.flag    = 1'b0;
      if (accept) begin
         case (req.command)
            deq_pkg::CMD_PUSH_HEAD: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            deq_pkg::CMD_PUSH_TAIL: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_pos;
                  count_in = count_ff + CW'(1);
               end
            end
            deq_pkg::CMD_POP_HEAD, deq_pkg::CMD_POP_TAIL: begin
               stage.valid = 1'b1;
               if (empty) begin
                  stage.value = deq_pkg::EMPTY_POP_VALUE;
                  stage.flag  = 1'b1;
               end else begin
                  stage.use_mem = 1'b1;
                  rd_en         = 1'b1;
                  count_in      = count_ff - CW'(1);
                  if (req.command == deq_pkg::CMD_POP_HEAD) begin
                     rd_addr = head_ff;
                     head_in = head_inc;
                  end else begin
                     rd_addr = back_pos;
                  end
               end
            end
            deq_pkg::CMD_SIZE: begin
               stage.valid = 1'b1;
               stage.value = deq_pkg::WORD_W'(count_ff);
            end
            deq_pkg::CMD_EMPTY: begin
               stage.valid = 1'b1;
               stage.value = deq_pkg::WORD_W'(empty);
            end
            deq_pkg::CMD_FRONT: begin
               if (!empty) begin
                  stage.valid   = 1'b1;
                  stage.use_mem = 1'b1;
                  rd_en         = 1'b1;
                  rd_addr       = head_ff;
               end
            end
            default: begin
               if (!empty) begin
                  stage.valid   = 1'b1;
                  stage.use_mem = 1'b1;
                  rd_en         = 1'b1;
                  rd_addr       = back_pos;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

[design/deq_out.sv]
module deq_out (
   input  logic                        clock,
   input  logic                        reset,
   input  deq_pkg::stage_type          stage,
   input  logic [deq_pkg::WORD_W-1:0]  rd_data,
   input  logic                        rsp_stall,
   output logic                        hold,
   output logic                        rsp_valid,
   output deq_pkg::rsp_type            rsp
);

   deq_pkg::stage_type s1_ff, s1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type   rsp_ff, rsp_in;
   logic               advance;

   always_comb begin
      advance = !rsp_valid_ff || !rsp_stall;
      hold    = s1_ff.valid && !advance;
      s1_in   = hold ? s1_ff : stage;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (s1_ff.valid && advance) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_value = s1_ff.use_mem ? $signed(rd_data) : s1_ff.value;
         rsp_in.empty_flag   = s1_ff.flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid  <= s1_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff.use_mem <= s1_in.use_mem;
      s1_ff.value   <= s1_in.value;
      s1_ff.flag    <= s1_in.flag;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[design/double_ended_queue_top.sv]
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  deq_pkg::req_type (command, push_value)
// rsp       out        rsp_valid / rsp_stall  deq_pkg::rsp_type (result_value, empty_flag)
//
// One item per cycle while req_stall is low; a result is registered in the stage register,
// alongside the registered read of the entry memory, and then in the output register.
// Pushes write the memory in the accept cycle; pointer and count update at once.
// Synchronous reset empties the queue at once; memory contents are not cleared.
// req_stall rises only while a finished result waits behind a stalled output register.
module double_ended_queue_top #(
   parameter int DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  deq_pkg::req_type   req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output deq_pkg::rsp_type   rsp
);

   localparam int AW = $clog2(DEPTH);

   logic                       accept;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [deq_pkg::WORD_W-1:0] wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [deq_pkg::WORD_W-1:0] rd_data;
   deq_pkg::stage_type         stage;
   logic                       hold;

   assign accept    = req_valid && !hold;
   assign req_stall = hold;

   deq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .stage   (stage)
   );

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   deq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   a_empty_pop_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.empty_flag) |-> (rsp.result_value == deq_pkg::EMPTY_POP_VALUE))
      else $error("empty pop without all-ones value");

   a_no_read_while_holding: assert property (@(posedge clock) disable iff (reset)
      hold |-> (!rd_en && !wr_en))
      else $error("memory accessed while result held");

endmodule
